>>> hw/rtl/modbus_rtu_slave_engine_assert.svh
// Assertion macros used by the checker module of the Modbus RTU slave engine.
`ifndef MODBUS_RTU_SLAVE_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_ENGINE_ASSERT_SVH

// Property checked only while out of reset.
`define MRSE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mrse assertion failed");

// Property checked at every edge, reset included.
`define MRSE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mrse assertion failed");

`endif

>>> hw/rtl/mrse_pkg.sv
// Package of the Modbus RTU slave engine: codes, defaults and shared types.
package mrse_pkg;
    localparam int RX_DEPTH_DEF = 32;
    localparam int NUM_REGS_DEF = 64;
    localparam int MAX_QTY_DEF  = 16;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_LOCAL = 2'd2;

    localparam logic [7:0] FN_READ  = 8'd3;
    localparam logic [7:0] FN_WRITE = 8'd6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;

    typedef struct packed {
        logic       init;
        logic       start;
        logic [7:0] data;
    } t_crc_ctl;
endpackage

>>> hw/rtl/mrse_if.sv
// Handshake channels of the Modbus RTU slave engine.
interface mrse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [5:0]  local_index;
    logic [15:0] local_value;
    modport source(output valid, cmd, rx_byte, local_index, local_value, input ready);
    modport sink(input valid, cmd, rx_byte, local_index, local_value, output ready);
endinterface

interface mrse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;
    modport source(output valid, tx_byte, last, input ready);
    modport sink(input valid, tx_byte, last, output ready);
endinterface

>>> hw/rtl/modbus_rtu_slave_engine.sv
// Modbus RTU slave engine: top level with frame store, register store and sequencer.
//
// Input channel i_in carries one transaction per received byte (cmd 0), frame-end
// silence (cmd 1) or a local holding register update (cmd 2). Output channel
// o_out returns the reply frame one byte per transaction, last set on the final
// CRC byte. i_cfg_we/i_cfg_data write the slave address (reset value 1).
// A received byte is written to the frame store and fed to the serial CRC unit,
// which runs one bit per cycle. A local update is written straight to the
// register store. A frame end with a good CRC and at least four bytes reads six
// header bytes from the frame store and decodes them, then builds the reply: each
// data byte runs through the CRC unit into the output register, a register high
// byte after a register store read, and the two CRC bytes follow. Other frames
// are dropped at once, and a frame for another address or function after decode.
// Only one input transaction is in work at a time; the input is ready again
// once the previous one is done, even while a reply byte waits in the output
// register. A stalled receiver holds the output byte and pauses the sequencer.
// Reset (synchronous, active low) empties the frame, sets the CRC to 0xFFFF,
// marks all holding registers as zero through per-entry valid bits and drops
// any pending output byte; no clearing pass is needed.
module modbus_rtu_slave_engine #(
    parameter int RX_DEPTH = mrse_pkg::RX_DEPTH_DEF,
    parameter int NUM_REGS = mrse_pkg::NUM_REGS_DEF,
    parameter int MAX_QTY  = mrse_pkg::MAX_QTY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrse_in_if.sink    i_in,
    mrse_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);
    localparam int CW  = $clog2(RX_DEPTH + 1);
    localparam int FAW = $clog2(RX_DEPTH);
    localparam int HAW = $clog2(NUM_REGS);
    localparam int QW  = $clog2(MAX_QTY + 1);
    localparam int TIW = $clog2(8 + 2 * MAX_QTY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RXCRC = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;
    localparam logic [3:0] S_HWT   = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_TCRC  = 4'd7;
    localparam logic [3:0] S_PUT   = 4'd8;

    logic [3:0]     r_state, n_state;
    logic [7:0]     r_slave;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_len, n_len;
    logic [2:0]     r_pos, n_pos;
    logic [7:0]     r_hdr [0:5];
    logic           r_fn3, n_fn3;
    logic [QW-1:0]  r_qty, n_qty;
    logic [TIW-1:0] r_ti, n_ti;
    logic [7:0]     r_cur, n_cur;
    logic [7:0]     r_wlo, n_wlo;
    logic           r_rdok, n_rdok;
    logic [NUM_REGS-1:0] r_hv, n_hv;
    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_obyte, n_obyte;
    logic           r_olast, n_olast;

    logic           in_acc;
    logic [15:0]    arg0, arg1;
    logic           arg0_ok;
    logic [TIW-1:0] ndata, rel;
    logic [16:0]    rnum;
    logic           rnum_ok;
    logic [HAW-1:0] raddr_h;
    logic           hdr_we;

    logic           fs_we;
    logic [FAW-1:0] fs_waddr, fs_raddr;
    logic [7:0]     fs_rdata;
    logic           hr_we;
    logic [HAW-1:0] hr_waddr;
    logic [15:0]    hr_wdata, hr_rdata;

    mrse_pkg::t_crc_ctl crc_ctl;
    logic [15:0]    crc;
    logic           crc_busy;

    mrse_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_frame_ram (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(i_in.rx_byte),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );

    mrse_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_reg_ram (
        .i_clk(i_clk), .i_we(hr_we), .i_waddr(hr_waddr), .i_wdata(hr_wdata),
        .i_raddr(raddr_h), .o_rdata(hr_rdata)
    );

    mrse_crc u_crc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(crc_ctl), .o_crc(crc), .o_busy(crc_busy)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign in_acc       = i_in.valid && i_in.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.tx_byte = r_obyte;
    assign o_out.last   = r_olast;

    assign arg0    = {r_hdr[2], r_hdr[3]};
    assign arg1    = {r_hdr[4], r_hdr[5]};
    assign arg0_ok = (arg0 >= 16'd1) && (32'(arg0) <= NUM_REGS);
    assign ndata   = r_fn3 ? (TIW'(3) + (TIW'(r_qty) << 1)) : TIW'(6);
    assign rel     = r_ti - TIW'(3);
    assign rnum    = {1'b0, arg0} + 17'(rel[TIW-1:1]);
    assign rnum_ok = (rnum >= 17'd1) && (32'(rnum) <= NUM_REGS);
    assign raddr_h = HAW'(rnum - 17'd1);
    assign fs_raddr = FAW'(r_pos);
    assign fs_waddr = r_count[FAW-1:0];
    assign hdr_we   = (r_state == S_HWT);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_len    = r_len;
        n_pos    = r_pos;
        n_fn3    = r_fn3;
        n_qty    = r_qty;
        n_ti     = r_ti;
        n_cur    = r_cur;
        n_wlo    = r_wlo;
        n_rdok   = r_rdok;
        n_hv     = r_hv;
        n_ovalid = r_ovalid && !o_out.ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        fs_we    = 1'b0;
        hr_we    = 1'b0;
        hr_waddr = HAW'(i_in.local_index);
        hr_wdata = i_in.local_value;
        crc_ctl  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.cmd)
                        mrse_pkg::CMD_BYTE: begin
                            if (r_count < CW'(RX_DEPTH)) begin
                                fs_we         = 1'b1;
                                crc_ctl.start = 1'b1;
                                crc_ctl.data  = i_in.rx_byte;
                                n_count       = r_count + CW'(1);
                                n_state       = S_RXCRC;
                            end
                        end
                        mrse_pkg::CMD_END: begin
                            n_len        = r_count;
                            n_count      = '0;
                            n_pos        = 3'd0;
                            crc_ctl.init = 1'b1;
                            if ((r_count >= CW'(4)) && (crc == 16'd0)) begin
                                n_state = S_HRD;
                            end
                        end
                        mrse_pkg::CMD_LOCAL: begin
                            if (32'(i_in.local_index) < NUM_REGS) begin
                                hr_we = 1'b1;
                                n_hv[HAW'(i_in.local_index)] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RXCRC: begin
                if (!crc_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_HRD: begin
                n_state = S_HWT;
            end
            S_HWT: begin
                if (r_pos == 3'd5) begin
                    n_state = S_DEC;
                end else begin
                    n_pos   = r_pos + 3'd1;
                    n_state = S_HRD;
                end
            end
            S_DEC: begin
                n_ti    = '0;
                n_fn3   = (r_hdr[1] == mrse_pkg::FN_READ);
                n_qty   = (32'(arg1) > MAX_QTY) ? QW'(MAX_QTY) : QW'(arg1);
                n_state = S_IDLE;
                if (r_hdr[0] == r_slave) begin
                    if (r_hdr[1] == mrse_pkg::FN_READ) begin
                        n_state = S_PREP;
                    end else if (r_hdr[1] == mrse_pkg::FN_WRITE) begin
                        n_state = S_PREP;
                        if (arg0_ok) begin
                            hr_we    = 1'b1;
                            hr_waddr = HAW'(arg0 - 16'd1);
                            hr_wdata = arg1;
                            n_hv[HAW'(arg0 - 16'd1)] = 1'b1;
                        end
                    end
                end
            end
            S_PREP: begin
                if (r_ti < ndata) begin
                    n_state = S_TCRC;
                    if (r_ti == TIW'(0)) begin
                        n_cur = r_slave;
                    end else if (r_ti == TIW'(1)) begin
                        n_cur = r_hdr[1];
                    end else if (r_fn3 && (r_ti == TIW'(2))) begin
                        n_cur = 8'({r_qty, 1'b0});
                    end else if (r_fn3) begin
                        n_cur = r_wlo;
                        if (!rel[0]) begin
                            n_rdok  = rnum_ok && r_hv[raddr_h];
                            n_state = S_RDW;
                        end
                    end else if (r_ti == TIW'(2)) begin
                        n_cur = r_hdr[2];
                    end else if (r_ti == TIW'(3)) begin
                        n_cur = r_hdr[3];
                    end else if (r_ti == TIW'(4)) begin
                        n_cur = arg0_ok ? r_hdr[4] : 8'd0;
                    end else begin
                        n_cur = arg0_ok ? r_hdr[5] : 8'd0;
                    end
                    if (n_state == S_TCRC) begin
                        crc_ctl.start = 1'b1;
                        crc_ctl.data  = n_cur;
                    end
                end else begin
                    n_cur   = (r_ti == ndata) ? crc[7:0] : crc[15:8];
                    n_state = S_PUT;
                end
            end
            S_RDW: begin
                n_cur         = r_rdok ? hr_rdata[15:8] : 8'd0;
                n_wlo         = r_rdok ? hr_rdata[7:0] : 8'd0;
                crc_ctl.start = 1'b1;
                crc_ctl.data  = n_cur;
                n_state       = S_TCRC;
            end
            S_TCRC: begin
                if (!crc_busy) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_cur;
                    n_olast  = (r_ti == ndata + TIW'(1));
                    n_ti     = r_ti + TIW'(1);
                    n_state  = n_olast ? S_IDLE : S_PREP;
                    // restart the receive CRC once the reply CRC is out
                    crc_ctl.init = n_olast;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slave  <= mrse_pkg::SLAVE_ADDR_RST;
            r_count  <= '0;
            r_hv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hv     <= n_hv;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_slave <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_pos   <= n_pos;
        r_fn3   <= n_fn3;
        r_qty   <= n_qty;
        r_ti    <= n_ti;
        r_cur   <= n_cur;
        r_wlo   <= n_wlo;
        r_rdok  <= n_rdok;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        if (hdr_we) begin
            r_hdr[r_pos] <= (CW'(r_pos) < r_len) ? fs_rdata : 8'd0;
        end
    end
endmodule

>>> hw/rtl/mrse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/mrse_crc.sv
// Bit-serial reflected CRC-16 unit, one bit per cycle.
module mrse_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrse_pkg::t_crc_ctl i_ctl,
    output logic [15:0]       o_crc,
    output logic              o_busy
);
    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_cnt, n_cnt;

    always_comb begin
        n_crc = r_crc;
        n_cnt = r_cnt;
        if (i_ctl.init) begin
            n_crc = mrse_pkg::CRC_INIT;
            n_cnt = 4'd0;
        end else if (i_ctl.start) begin
            n_crc = r_crc ^ {8'd0, i_ctl.data};
            n_cnt = 4'd8;
        end else if (r_cnt != 4'd0) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ mrse_pkg::CRC_POLY) : (r_crc >> 1);
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= mrse_pkg::CRC_INIT;
            r_cnt <= 4'd0;
        end else begin
            r_crc <= n_crc;
            r_cnt <= n_cnt;
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = (r_cnt != 4'd0);
endmodule

>>> hw/rtl/mrse_checker.sv
// Port-level checker for the Modbus RTU slave engine, bound to the top level.
`include "modbus_rtu_slave_engine_assert.svh"

module mrse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready
);
    `MRSE_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `MRSE_ASSERT(a_local_one_cycle, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_cmd == mrse_pkg::CMD_LOCAL |=> i_in_ready)
    `MRSE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind modbus_rtu_slave_engine mrse_checker u_mrse_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_in_cmd(i_in.cmd),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);
